// ===== src/qsh_pkg.sv =====
// Package: shared constants and codes for the trace classifier.
package qsh_pkg;
   localparam int STORE_DEPTH_DEF = 1024;
   localparam int VALUE_WIDTH_DEF = 32;

   localparam logic [1:0] MODE_PUSH   = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_START  = 2'd2;

   localparam logic [2:0] VERDICT_IMPOSSIBLE = 3'd0;
   localparam logic [2:0] VERDICT_NOT_SURE   = 3'd1;
   localparam logic [2:0] VERDICT_QUEUE      = 3'd2;
   localparam logic [2:0] VERDICT_STACK      = 3'd3;
   localparam logic [2:0] VERDICT_PRIORITY   = 3'd4;
endpackage

// ===== src/qsh_ram.sv =====
// Single-port-write, single-port-read memory with registered read data.
module qsh_ram #(
   parameter int DEPTH = qsh_pkg::STORE_DEPTH_DEF,
   parameter int WIDTH = qsh_pkg::VALUE_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== src/queue_stack_heap_trace_classifier_unit.sv =====
// Top level: sequencer around the FIFO, stack and heap memories.
// An item is taken when start is high and busy low; its result appears with
// rsp_valid for one cycle and cannot be stalled. Start, unused-mode,
// dropped-push and empty-remove items go straight to the result; a push
// climbs the heap one level per parent read and compare; a remove reads the
// stores and then, unless it empties them, sifts the heap down one level per
// left read, right read and compare. The heap memory's single read port sets
// the pace. No clearing pass is needed after reset.
module queue_stack_heap_trace_classifier_unit #(
   parameter int STORE_DEPTH = qsh_pkg::STORE_DEPTH_DEF,
   parameter int VALUE_WIDTH = qsh_pkg::VALUE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_mode,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   output logic                   rsp_valid,
   output logic [2:0]             rsp_verdict,
   output logic [$clog2(STORE_DEPTH+1)-1:0] rsp_occupancy,
   output logic                   rsp_overflow
);
   localparam int AW = $clog2(STORE_DEPTH);
   localparam int CW = $clog2(STORE_DEPTH + 1);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_PU_RD  = 4'd1;  // read parent
   localparam logic [3:0] ST_PU_CMP = 4'd2;  // compare parent with key
   localparam logic [3:0] ST_RM_RD0 = 4'd3;  // read fifo front, stack top and heap top
   localparam logic [3:0] ST_RM_RD1 = 4'd4;  // read last
   localparam logic [3:0] ST_RM_CMP = 4'd5;  // compare heap top with key
   localparam logic [3:0] ST_SF_RDL = 4'd6;  // read left child
   localparam logic [3:0] ST_SF_RDR = 4'd7;  // read right child
   localparam logic [3:0] ST_SF_CMP = 4'd8;  // choose and move
   localparam logic [3:0] ST_DONE   = 4'd10;

   logic [3:0]  state_ff, state_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [AW-1:0] head_ff, head_in;
   logic still_fifo_ff, still_fifo_in;
   logic still_lifo_ff, still_lifo_in;
   logic still_heap_ff, still_heap_in;
   logic overflow_ff, overflow_in;
   logic [VALUE_WIDTH-1:0] key_ff, key_in;
   logic [VALUE_WIDTH-1:0] last_ff, last_in;
   logic [VALUE_WIDTH-1:0] left_ff, left_in;
   logic [VALUE_WIDTH-1:0] top_ff, top_in;
   logic [CW-1:0] pos_ff, pos_in;

   // memory ports
   logic          fifo_we, stack_we, heap_we;
   logic [AW-1:0] fifo_wa, stack_wa, heap_wa, fifo_ra, stack_ra, heap_ra;
   logic [VALUE_WIDTH-1:0] fifo_wd, heap_wd, fifo_rd, stack_rd, heap_rd;

   qsh_ram #(.DEPTH(STORE_DEPTH), .WIDTH(VALUE_WIDTH)) u_fifo (
      .clock(clock), .wr_en(fifo_we), .wr_addr(fifo_wa), .wr_data(fifo_wd),
      .rd_addr(fifo_ra), .rd_data(fifo_rd));
   qsh_ram #(.DEPTH(STORE_DEPTH), .WIDTH(VALUE_WIDTH)) u_stack (
      .clock(clock), .wr_en(stack_we), .wr_addr(stack_wa), .wr_data(fifo_wd),
      .rd_addr(stack_ra), .rd_data(stack_rd));
   qsh_ram #(.DEPTH(STORE_DEPTH), .WIDTH(VALUE_WIDTH)) u_heap (
      .clock(clock), .wr_en(heap_we), .wr_addr(heap_wa), .wr_data(heap_wd),
      .rd_addr(heap_ra), .rd_data(heap_rd));

   logic accept;
   logic [CW-1:0] parent;
   logic [CW:0] lchild, rchild, tail_sum;
   logic rgt_ok;
   logic [VALUE_WIDTH-1:0] best_child;
   logic [CW-1:0] best_pos;

   assign accept = start && !busy;
   assign busy   = state_ff != ST_IDLE;
   assign parent = (pos_ff - CW'(1)) >> 1;
   assign lchild = {pos_ff, 1'b1};
   assign rchild = lchild + (CW+1)'(1);
   assign tail_sum = (CW+1)'(head_ff) + {1'b0, fill_ff};
   assign rgt_ok = rchild < {1'b0, fill_ff};
   // signed greater-than between right (heap_rd) and left child
   assign best_child = (rgt_ok && ($signed(heap_rd) > $signed(left_ff))) ? heap_rd : left_ff;
   assign best_pos   = (rgt_ok && ($signed(heap_rd) > $signed(left_ff))) ?
                       CW'(rchild) : CW'(lchild);

   // sequencer
   always_comb begin
      state_in = state_ff;
      fill_in = fill_ff;
      head_in = head_ff;
      still_fifo_in = still_fifo_ff;
      still_lifo_in = still_lifo_ff;
      still_heap_in = still_heap_ff;
      overflow_in = overflow_ff;
      key_in = key_ff;
      last_in = last_ff;
      left_in = left_ff;
      top_in = top_ff;
      pos_in = pos_ff;
      fifo_we = 1'b0; stack_we = 1'b0; heap_we = 1'b0;
      fifo_wa = '0; stack_wa = '0; heap_wa = '0;
      fifo_wd = key_ff; heap_wd = key_ff;
      fifo_ra = head_ff; stack_ra = '0; heap_ra = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               key_in = req_value;
               state_in = ST_DONE;
               case (req_mode)
                  qsh_pkg::MODE_START: begin
                     fill_in = '0; head_in = '0; overflow_in = 1'b0;
                     still_fifo_in = 1'b1; still_lifo_in = 1'b1; still_heap_in = 1'b1;
                  end
                  qsh_pkg::MODE_PUSH: begin
                     if (fill_ff >= CW'(STORE_DEPTH)) begin
                        overflow_in = 1'b1;
                     end else begin
                        fifo_we = 1'b1; stack_we = 1'b1;
                        fifo_wd = req_value;
                        fifo_wa = (tail_sum >= (CW+1)'(STORE_DEPTH)) ?
                                  AW'(tail_sum - (CW+1)'(STORE_DEPTH)) : AW'(tail_sum);
                        stack_wa = AW'(fill_ff);
                        pos_in = fill_ff;
                        fill_in = fill_ff + CW'(1);
                        state_in = ST_PU_RD;
                     end
                  end
                  qsh_pkg::MODE_REMOVE: begin
                     if (fill_ff == '0) begin
                        still_fifo_in = 1'b0; still_lifo_in = 1'b0; still_heap_in = 1'b0;
                     end else begin
                        fill_in = fill_ff - CW'(1);
                        state_in = ST_RM_RD0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         // climb: pos is the hole; stop at root or when parent >= key
         ST_PU_RD: begin
            if (pos_ff == '0) begin
               heap_we = 1'b1; heap_wa = '0;
               state_in = ST_DONE;
            end else begin
               heap_ra = AW'(parent);
               state_in = ST_PU_CMP;
            end
         end
         ST_PU_CMP: begin
            heap_we = 1'b1;
            heap_wa = AW'(pos_ff);
            if ($signed(heap_rd) >= $signed(key_ff)) begin
               state_in = ST_DONE;
            end else begin
               heap_wd = heap_rd;
               pos_in = parent;
               state_in = ST_PU_RD;
            end
         end
         // removal: read fifo front, stack top and heap top
         ST_RM_RD0: begin
            fifo_ra = head_ff;
            stack_ra = AW'(fill_ff);
            heap_ra = '0;
            state_in = ST_RM_RD1;
         end
         ST_RM_RD1: begin
            heap_ra = AW'(fill_ff);
            if (fifo_rd != key_ff) still_fifo_in = 1'b0;
            if (stack_rd != key_ff) still_lifo_in = 1'b0;
            top_in = heap_rd;
            head_in = (head_ff == AW'(STORE_DEPTH - 1)) ? '0 : head_ff + AW'(1);
            state_in = ST_RM_CMP;
         end
         ST_RM_CMP: begin
            if (top_ff != key_ff) still_heap_in = 1'b0;
            last_in = heap_rd;
            pos_in = '0;
            state_in = (fill_ff == '0) ? ST_DONE : ST_SF_RDL;
         end
         ST_SF_RDL: begin
            if (lchild >= {1'b0, fill_ff}) begin
               heap_we = 1'b1; heap_wa = AW'(pos_ff); heap_wd = last_ff;
               state_in = ST_DONE;
            end else begin
               heap_ra = AW'(lchild);
               state_in = ST_SF_RDR;
            end
         end
         // left data lands; right child read lands in the compare cycle
         ST_SF_RDR: begin
            heap_ra = AW'(rchild);
            left_in = heap_rd;
            state_in = ST_SF_CMP;
         end
         ST_SF_CMP: begin
            heap_we = 1'b1; heap_wa = AW'(pos_ff);
            if ($signed(best_child) <= $signed(last_ff)) begin
               heap_wd = last_ff;
               state_in = ST_DONE;
            end else begin
               heap_wd = best_child;
               pos_in = best_pos;
               state_in = ST_SF_RDL;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff <= '0; head_ff <= '0;
         still_fifo_ff <= 1'b1; still_lifo_ff <= 1'b1; still_heap_ff <= 1'b1;
         overflow_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in; head_ff <= head_in;
         still_fifo_ff <= still_fifo_in; still_lifo_ff <= still_lifo_in;
         still_heap_ff <= still_heap_in; overflow_ff <= overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in; last_ff <= last_in; left_ff <= left_in;
      top_ff <= top_in; pos_ff <= pos_in;
   end

   // verdict from the three flags
   logic [1:0] nflags;
   assign nflags = 2'(still_fifo_ff) + 2'(still_lifo_ff) + 2'(still_heap_ff);
   always_comb begin
      if (nflags == 2'd0)      rsp_verdict = qsh_pkg::VERDICT_IMPOSSIBLE;
      else if (nflags > 2'd1)  rsp_verdict = qsh_pkg::VERDICT_NOT_SURE;
      else if (still_fifo_ff)  rsp_verdict = qsh_pkg::VERDICT_QUEUE;
      else if (still_lifo_ff)  rsp_verdict = qsh_pkg::VERDICT_STACK;
      else                     rsp_verdict = qsh_pkg::VERDICT_PRIORITY;
   end
   assign rsp_valid = state_ff == ST_DONE;
   assign rsp_occupancy = fill_ff;
   assign rsp_overflow = overflow_ff;

`ifndef NO_ASSERTIONS
   a_occ: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(STORE_DEPTH)) else $error("occupancy beyond depth");
   a_one: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy) else $error("not busy in cycle after accept");
   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("not idle after result");
`endif
endmodule
